### src/rmth_pkg.sv
// shared constants and types of the running median block
package rmth_pkg;

  localparam int HEAP_DEPTH = 512;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int SUM_W      = $clog2(2 * HEAP_DEPTH + 1);
  localparam int DATA_W     = 32;
  localparam int MED_W      = DATA_W + 1;

  typedef struct packed {
    logic                     go;
    logic                     replace;
    logic signed [DATA_W-1:0] value;
  } heap_cmd_t;

  typedef struct packed {
    logic                     busy;
    logic signed [DATA_W-1:0] top;
    logic [CNT_W-1:0]         count;
  } heap_stat_t;

endpackage

### src/running_median_two_heaps.sv
// top level of the running median block built on two memory heaps
//
// usage:
// - in_valid/in_stall carry one signed 32-bit sample per request; a request
//   is taken when in_valid is high and in_stall is low
// - out_valid/out_stall carry one result per sample: twice the median of all
//   samples held, the held count and a dropped flag
// - the lower half sits in a max-heap and the upper half in a min-heap, each
//   in its own single-port-read memory; both heap roots are cached in
//   registers so the steering decision needs no memory read
// - a sample costs at most one sift in each heap, and the two run at once;
//   a sift step going up reads the parent, then compares; going down it
//   reads the left child, then the right child, then compares; the next
//   request is taken only after the result is loaded to the output register
// - once 1024 samples are held, further samples are dropped and the result
//   repeats the unchanged median with dropped set
// - reset empties both heaps through their counts; memory contents are not
//   cleared, and entries past the count may be read but are never used
// - while out_stall holds a result, the next sample is still taken and
//   worked on; it waits for the output register before its result is posted
module running_median_two_heaps (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rmth_pkg::DATA_W-1:0]  in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rmth_pkg::MED_W-1:0]   out_median_twice,
  output logic [rmth_pkg::SUM_W-1:0]          out_sample_count,
  output logic                                out_dropped
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WAIT = 2'b10
  } top_state_t;

  top_state_t state_r, state_nxt;

  rmth_pkg::heap_cmd_t  lo_cmd, hi_cmd;
  rmth_pkg::heap_stat_t lo_st, hi_st;

  logic in_acc;
  logic full;
  logic go_lower;
  logic drop_r, drop_nxt;
  logic out_load;
  logic [rmth_pkg::SUM_W-1:0] total;
  logic signed [rmth_pkg::MED_W-1:0] med;

  logic                               out_valid_r;
  logic signed [rmth_pkg::MED_W-1:0]  med_r;
  logic [rmth_pkg::SUM_W-1:0]         cnt_r;
  logic                               dropped_r;

  rmth_heap u_lower (
    .clk    (clk),
    .rst_n  (rst_n),
    .is_max (1'b1),
    .cmd    (lo_cmd),
    .stat   (lo_st)
  );

  rmth_heap u_upper (
    .clk    (clk),
    .rst_n  (rst_n),
    .is_max (1'b0),
    .cmd    (hi_cmd),
    .stat   (hi_st)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign total    = rmth_pkg::SUM_W'(lo_st.count) + rmth_pkg::SUM_W'(hi_st.count);
  assign full     = total >= rmth_pkg::SUM_W'(2 * rmth_pkg::HEAP_DEPTH);
  assign go_lower = (lo_st.count == '0) || (in_sample <= lo_st.top);

  // steering: an overflow of one half is merged into a root replace on that
  // side plus a push of the old root on the other side, both at once
  always_comb begin
    lo_cmd       = '0;
    hi_cmd       = '0;
    lo_cmd.value = in_sample;
    hi_cmd.value = in_sample;
    drop_nxt     = drop_r;
    if (in_acc) begin
      drop_nxt = full;
      if (!full) begin
        if (go_lower) begin
          lo_cmd.go = 1'b1;
          if (lo_st.count > hi_st.count) begin
            // lower top moves up, sample replaces it
            lo_cmd.replace = 1'b1;
            hi_cmd.go      = 1'b1;
            hi_cmd.value   = lo_st.top;
          end
        end else if (hi_st.count >= lo_st.count) begin
          lo_cmd.go = 1'b1;
          if (hi_st.count != '0 && in_sample > hi_st.top) begin
            // upper top moves down, sample replaces it
            hi_cmd.go      = 1'b1;
            hi_cmd.replace = 1'b1;
            lo_cmd.value   = hi_st.top;
          end
        end else begin
          hi_cmd.go = 1'b1;
        end
      end
    end
  end

  // median from the cached roots once both sifts are done
  always_comb begin
    if (lo_st.count == hi_st.count) begin
      med = rmth_pkg::MED_W'(lo_st.top) + rmth_pkg::MED_W'(hi_st.top);
    end else begin
      med = {lo_st.top, 1'b0};
    end
  end

  assign out_load = (state_r == S_WAIT) && !lo_st.busy && !hi_st.busy
                    && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_WAIT;
      S_WAIT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    drop_r <= drop_nxt;
    if (out_load) begin
      med_r     <= med;
      cnt_r     <= total;
      dropped_r <= drop_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_median_twice = med_r;
  assign out_sample_count = cnt_r;
  assign out_dropped      = dropped_r;

endmodule

### src/rmth_heap.sv
// one binary heap in a synchronous memory with push and replace-root sifts
module rmth_heap (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 is_max,
  input  rmth_pkg::heap_cmd_t  cmd,
  output rmth_pkg::heap_stat_t stat
);

  typedef enum logic [5:0] {
    H_IDLE   = 6'b000001,
    H_UP_RD  = 6'b000010,
    H_UP_CMP = 6'b000100,
    H_DN_L   = 6'b001000,
    H_DN_R   = 6'b010000,
    H_DN_C   = 6'b100000
  } heap_state_t;

  heap_state_t state_r, state_nxt;

  logic signed [rmth_pkg::DATA_W-1:0] mem [rmth_pkg::HEAP_DEPTH];
  logic signed [rmth_pkg::DATA_W-1:0] rdata_r;
  logic [rmth_pkg::IDX_W-1:0]         raddr;
  logic                               we;
  logic [rmth_pkg::IDX_W-1:0]         waddr;
  logic signed [rmth_pkg::DATA_W-1:0] wdata;

  logic [rmth_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [rmth_pkg::IDX_W-1:0]         pos_r, pos_nxt;
  logic signed [rmth_pkg::DATA_W-1:0] val_r, val_nxt;
  logic signed [rmth_pkg::DATA_W-1:0] lv_r, lv_nxt;
  logic signed [rmth_pkg::DATA_W-1:0] top_r;

  logic [rmth_pkg::IDX_W-1:0] parent;
  logic [rmth_pkg::IDX_W+1:0] lidx, ridx;
  logic                       l_ok, r_ok, take_l, take_r;
  logic signed [rmth_pkg::DATA_W-1:0] best_l;

  function automatic logic above(input logic signed [rmth_pkg::DATA_W-1:0] a,
                                 input logic signed [rmth_pkg::DATA_W-1:0] b,
                                 input logic mx);
    above = mx ? (a > b) : (a < b);
  endfunction

  assign parent = rmth_pkg::IDX_W'((pos_r - 1'b1) >> 1);
  assign lidx   = {1'b0, pos_r, 1'b1};
  assign ridx   = lidx + 1'b1;
  assign l_ok   = lidx < (rmth_pkg::IDX_W+2)'(cnt_r);
  assign r_ok   = ridx < (rmth_pkg::IDX_W+2)'(cnt_r);
  assign take_l = l_ok && above(lv_r, val_r, is_max);
  assign best_l = take_l ? lv_r : val_r;
  assign take_r = r_ok && above(rdata_r, best_l, is_max);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    lv_nxt    = lv_r;
    raddr     = parent;
    we        = 1'b0;
    waddr     = pos_r;
    wdata     = val_r;
    unique case (state_r)
      H_IDLE: begin
        if (cmd.go) begin
          val_nxt = cmd.value;
          if (cmd.replace) begin
            pos_nxt   = '0;
            state_nxt = H_DN_L;
          end else begin
            pos_nxt   = rmth_pkg::IDX_W'(cnt_r);
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = H_UP_RD;
          end
        end
      end
      H_UP_RD: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          state_nxt = H_UP_CMP;
        end
      end
      H_UP_CMP: begin
        we = 1'b1;
        if (above(val_r, rdata_r, is_max)) begin
          wdata     = rdata_r;
          pos_nxt   = parent;
          state_nxt = H_UP_RD;
        end else begin
          state_nxt = H_IDLE;
        end
      end
      H_DN_L: begin
        raddr     = lidx[rmth_pkg::IDX_W-1:0];
        state_nxt = H_DN_R;
      end
      H_DN_R: begin
        raddr     = ridx[rmth_pkg::IDX_W-1:0];
        lv_nxt    = rdata_r;
        state_nxt = H_DN_C;
      end
      H_DN_C: begin
        we = 1'b1;
        if (take_r) begin
          wdata     = rdata_r;
          pos_nxt   = ridx[rmth_pkg::IDX_W-1:0];
          state_nxt = H_DN_L;
        end else if (take_l) begin
          wdata     = lv_r;
          pos_nxt   = lidx[rmth_pkg::IDX_W-1:0];
          state_nxt = H_DN_L;
        end else begin
          state_nxt = H_IDLE;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    lv_r  <= lv_nxt;
    if (we && waddr == '0) top_r <= wdata;
  end

  assign stat.busy  = (state_r != H_IDLE);
  assign stat.top   = top_r;
  assign stat.count = cnt_r;

endmodule
